/* rtl/cobs_pkg.sv */
// ----------------------------------------------------------------------------
// cobs_pkg
// Shared types and constants for the chroma transposition-index similarity
// core: frame geometry, arithmetic widths, word types and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cobs_pkg;

	localparam int NUM_BINS   = 12;
	localparam int BIN_BITS   = 16;
	localparam int SHIFT_W    = 4;
	localparam int BIN_IDX_W  = $clog2(NUM_BINS);
	localparam int PROD_W     = 2 * BIN_BITS;
	localparam int GROUP      = 4;
	localparam int NUM_GROUPS = (NUM_BINS + GROUP - 1) / GROUP;
	localparam int GSUM_W     = PROD_W + $clog2(GROUP);
	localparam int SUM_W      = PROD_W + $clog2(NUM_BINS);

	localparam logic [SHIFT_W-1:0]   SHIFT_COUNT_RESET = SHIFT_W'(12);
	localparam logic [SHIFT_W-1:0]   MATCH_MAX_SHIFT   = SHIFT_W'(1);
	localparam logic [BIN_IDX_W-1:0] LAST_BIN          = BIN_IDX_W'(NUM_BINS - 1);

	typedef logic [BIN_BITS-1:0] bin_t;

	typedef struct packed {
		logic [15:0] query_bin;
		logic [15:0] reference_bin;
	} cobs_in_t;

	typedef struct packed {
		logic              match;
		logic [SHIFT_W-1:0] best_shift;
	} cobs_out_t;

	typedef struct packed {
		logic                 load_en;
		logic [BIN_IDX_W-1:0] bin_idx;
		logic                 eval_issue;
		logic                 eval_first;
		logic                 eval_last;
		logic [SHIFT_W-1:0]   shift_idx;
		logic                 out_load;
	} cobs_cmd_t;

	typedef struct packed {
		logic eval_done;
	} cobs_sts_t;

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} cobs_state_t;

endpackage

/* rtl/cobs_ctrl.sv */
// ----------------------------------------------------------------------------
// cobs_ctrl
// Controller: counts loaded bins, issues one shift per cycle to the datapath,
// waits for the product pipeline to drain and hands the result to the output
// register. Also holds the shift count register.
// ----------------------------------------------------------------------------
module cobs_ctrl
	import cobs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_wr_en,
	input  logic [SHIFT_W-1:0] cfg_wr_data,
	output cobs_cmd_t          cmd,
	input  cobs_sts_t          sts
);

	cobs_state_t          state_q, state_d;
	logic [BIN_IDX_W-1:0] bin_cnt_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [SHIFT_W-1:0]   shift_count_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 out_free;

	assign in_ready  = (state_q == ST_LOAD);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_en    = accept;
		cmd.bin_idx    = bin_cnt_q;
		cmd.eval_issue = (state_q == ST_EVAL);
		cmd.eval_first = (shift_q == '0);
		cmd.eval_last  = (shift_q == shift_count_q);
		cmd.shift_idx  = shift_q;
		cmd.out_load   = (state_q == ST_FINISH) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && (bin_cnt_q == LAST_BIN)) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cmd.eval_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.eval_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			bin_cnt_q     <= '0;
			shift_q       <= '0;
			shift_count_q <= SHIFT_COUNT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) shift_count_q <= cfg_wr_data;
			if (accept) begin
				bin_cnt_q <= (bin_cnt_q == LAST_BIN) ? '0 : bin_cnt_q + 1'b1;
			end
			if (state_q == ST_EVAL) shift_q <= shift_q + 1'b1;
			else shift_q <= '0;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// The pipeline may only report completion while the controller waits for it.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sts.eval_done |-> state_q == ST_DRAIN)
		else $error("evaluation finished outside drain");

	// Evaluation starts only after a complete frame pair, so the bin count is back at zero.
	a_eval_after_full_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> bin_cnt_q == '0)
		else $error("evaluation with a partial frame");

	// A new result word is only posted from the finish step.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result posted outside finish");

endmodule

/* rtl/cobs_dp.sv */
// ----------------------------------------------------------------------------
// cobs_dp
// Datapath: query and reference bin registers, a reference ring that rotates
// right by one bin per issued shift, one multiplier per bin, a registered
// adder tree, the running maximum and the result register.
// ----------------------------------------------------------------------------
module cobs_dp
	import cobs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cobs_cmd_t cmd,
	output cobs_sts_t sts,
	input  cobs_in_t  in_data,
	output cobs_out_t out_data
);

	bin_t                query_q [NUM_BINS];
	bin_t                ref_q   [NUM_BINS];

	logic [PROD_W-1:0]   prod_s1 [NUM_BINS];
	logic                vld_s1, first_s1, last_s1;
	logic [SHIFT_W-1:0]  shift_s1;

	logic [GSUM_W-1:0]   gsum_c  [NUM_GROUPS];
	logic [GSUM_W-1:0]   gsum_s2 [NUM_GROUPS];
	logic                vld_s2, first_s2, last_s2;
	logic [SHIFT_W-1:0]  shift_s2;

	logic [SUM_W-1:0]    total_c;
	logic [SUM_W-1:0]    total_s3;
	logic                vld_s3, first_s3, last_s3;
	logic [SHIFT_W-1:0]  shift_s3;

	logic [SUM_W-1:0]    best_val_q;
	logic [SHIFT_W-1:0]  best_q;
	logic                done_q;
	cobs_out_t           out_q;

	// Loading writes one bin pair; evaluation rotates the reference ring right
	// by one so that each issued shift sees the next rotation.
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			query_q[cmd.bin_idx] <= bin_t'(in_data.query_bin);
			ref_q[cmd.bin_idx]   <= bin_t'(in_data.reference_bin);
		end else if (cmd.eval_issue) begin
			for (int n = 0; n < NUM_BINS; n++) begin
				ref_q[n] <= ref_q[(n + NUM_BINS - 1) % NUM_BINS];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < NUM_BINS; n++) begin
			prod_s1[n] <= PROD_W'(query_q[n]) * PROD_W'(ref_q[n]);
		end
		first_s1 <= cmd.eval_first;
		last_s1  <= cmd.eval_last;
		shift_s1 <= cmd.shift_idx;
	end

	always_comb begin
		int idx;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			gsum_c[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				idx = (g * GROUP + j < NUM_BINS) ? g * GROUP + j : 0;
				if (g * GROUP + j < NUM_BINS) gsum_c[g] = gsum_c[g] + GSUM_W'(prod_s1[idx]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			gsum_s2[g] <= gsum_c[g];
		end
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		shift_s2 <= shift_s1;
	end

	always_comb begin
		total_c = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			total_c = total_c + SUM_W'(gsum_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		total_s3 <= total_c;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		shift_s3 <= shift_s2;
	end

	// Strictly greater keeps the lowest shift among equal maxima.
	always_ff @(posedge clk) begin
		if (vld_s3 && (first_s3 || (total_s3 > best_val_q))) begin
			best_val_q <= total_s3;
			best_q     <= shift_s3;
		end
		if (cmd.out_load) begin
			out_q.match      <= (best_q <= MATCH_MAX_SHIFT);
			out_q.best_shift <= best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.eval_issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3 && last_s3;
		end
	end

	assign sts.eval_done = done_q;
	assign out_data      = out_q;

	// The winning shift can never lie beyond the last shift evaluated.
	a_best_within_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> best_q <= $past(shift_s3))
		else $error("best shift beyond last evaluated shift");

endmodule

/* rtl/chroma_oti_binary_similarity_core.sv */
// ----------------------------------------------------------------------------
// chroma_oti_binary_similarity_core
// Loads a query and a reference chroma frame one bin pair per word, then
// finds the first rotation of the reference frame (0 to shift_count) giving
// the greatest exact dot product with the query, and reports it with a match
// flag.
//
//   Channel   Direction  Handshake              Word
//   in        sink       in_valid / in_ready    cobs_in_t (query, reference bin)
//   out       source     out_valid / out_ready  cobs_out_t (match, best_shift)
//   cfg       sink       cfg_wr_en              shift_count, 4 bits
//
// A frame pair is loaded one bin pair per cycle, then shift_count + 1
// rotations are issued, one per cycle, to the bank of NUM_BINS multipliers;
// each product sum then passes through the adder tree, the maximum and the
// result register.
// Input is taken only while loading. A result waiting on out_ready does not
// block loading of the next frame; it stalls only the next result.
// Reset clears the controller and shift_count (to 12); bin stores are not
// cleared.
// ----------------------------------------------------------------------------
module chroma_oti_binary_similarity_core
	import cobs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cobs_in_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cobs_out_t          out_data,
	input  logic               cfg_wr_en,
	input  logic [SHIFT_W-1:0] cfg_wr_data
);

	cobs_cmd_t cmd;
	cobs_sts_t sts;

	cobs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

	cobs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule
